[rtl/tst_pkg.sv]
`timescale 1ns / 1ps
// Shared constants, register codes and result type of the tilt servo tag tracker.
package tst_pkg;

    // Field widths
    localparam int unsigned ROW_W    = 10;
    localparam int unsigned ID_W     = 10;
    localparam int unsigned GAIN_W   = 16;
    localparam int unsigned DEG_W    = 8;
    localparam int unsigned POSE_W   = 16;
    localparam int unsigned TICK_W   = 16;
    localparam int unsigned SEEN_W   = 7;
    localparam int unsigned LOWCNT_W = 12;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_ROW  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_UPPER_ROW   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LOWER_ROW   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_POSE_MIN    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_POSE_MAX    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_VALID_TICKS = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_LOST_TICKS  = 3'd7;

    // Command codes
    localparam logic CMD_TICK   = 1'b0;
    localparam logic CMD_DETECT = 1'b1;

    // Fixed constants
    localparam logic [ID_W-1:0]     TARGET_ID       = 10'd25;
    localparam logic [DEG_W-1:0]    SERVO_MIN       = 8'd43;
    localparam logic [DEG_W-1:0]    SERVO_MAX       = 8'd150;
    localparam logic [DEG_W-1:0]    SERVO_RESET     = 8'd100;
    localparam logic [DEG_W-1:0]    LOW_ANGLE_POS   = 8'd77;
    localparam logic [LOWCNT_W-1:0] LOW_CNT_MAX     = 12'd4000;
    localparam logic [LOWCNT_W-1:0] LOW_CNT_TRIP    = 12'd100;
    localparam logic [TICK_W-1:0]   FORCED_WATCHDOG = 16'd3000;
    localparam int unsigned         PHASE_OFFSET    = 1500;
    localparam logic [SEEN_W-1:0]   SEEN_MAX        = 7'd100;
    localparam logic [SEEN_W-1:0]   LOCK_SEEN       = 7'd3;
    localparam logic [POSE_W-1:0]   POSE_RESET      = 16'd25600;
    localparam logic [POSE_W-1:0]   LOST_START_POSE = 16'd38400;
    localparam logic [POSE_W-1:0]   POSE_ONE_DEG    = 16'd256;

    // Reset values of the configuration registers
    localparam logic [ROW_W-1:0]  CENTER_ROW_RESET  = 10'd240;
    localparam logic [ROW_W-1:0]  UPPER_ROW_RESET   = 10'd250;
    localparam logic [ROW_W-1:0]  LOWER_ROW_RESET   = 10'd230;
    localparam logic [GAIN_W-1:0] GAIN_RESET        = 16'd1507;
    localparam logic [DEG_W-1:0]  POSE_MIN_RESET    = 8'd52;
    localparam logic [DEG_W-1:0]  POSE_MAX_RESET    = 8'd148;
    localparam logic [TICK_W-1:0] VALID_TICKS_RESET = 16'd80;
    localparam logic [TICK_W-1:0] LOST_TICKS_RESET  = 16'd2000;

    typedef struct packed {
        logic [DEG_W-1:0] servo_pos;
        logic             servo_write;
        logic             track_valid;
        logic             tag_lost;
        logic             target_locked;
    } result_t;

endpackage

[rtl/tst_if.sv]
`timescale 1ns / 1ps
// Handshake channel interfaces: detection/tick requests, results, register writes.
interface tst_item_if;
    import tst_pkg::*;

    logic            valid;
    logic            ready;
    logic            command;
    logic [ID_W-1:0] tag_id;
    logic [ROW_W-1:0] tag_row;

    modport source (output valid, output command, output tag_id, output tag_row, input ready);
    modport sink   (input valid, input command, input tag_id, input tag_row, output ready);
endinterface

interface tst_result_if;
    import tst_pkg::*;

    logic             valid;
    logic             ready;
    logic [DEG_W-1:0] servo_pos;
    logic             servo_write;
    logic             track_valid;
    logic             tag_lost;
    logic             target_locked;

    modport source (output valid, output servo_pos, output servo_write, output track_valid,
                    output tag_lost, output target_locked, input ready);
    modport sink   (input valid, input servo_pos, input servo_write, input track_valid,
                    input tag_lost, input target_locked, output ready);
endinterface

interface tst_cfg_if;
    import tst_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/tilt_servo_tag_tracker.sv]
`timescale 1ns / 1ps
// Top level of the tilt servo tag tracker: state update, result buffer, config registers.

// The tracker takes one request per clock cycle while its skid entry is free,
// either a timer tick or a tag detection, and returns exactly one result per
// request. A request is worked out in the cycle it is accepted: one 10x16
// multiply (row error times gain), a subtract, an add and two clamps for a
// detection, or the watchdog and sweep counters for a tick, all landing in the
// state registers and in the result register, or in the skid entry while the
// head still waits, at the same edge. A two-entry result buffer (result register
// plus one skid entry) lets a new request enter while a finished result still
// waits; the request side stalls only when both entries are full. Sustained rate
// is one request per cycle whenever results are drained at that rate. Register
// writes are always taken at once and must only be made while no result is pending.
module tilt_servo_tag_tracker #(
    parameter int unsigned SWEEP_PERIOD = 50
) (
    input  logic           clk,
    input  logic           rst_n,
    tst_cfg_if.sink        cfg,
    tst_item_if.sink       items,
    tst_result_if.source   results
);
    import tst_pkg::*;

    localparam int unsigned PHASE_W = $clog2(SWEEP_PERIOD);
    // Phase of a given watchdog value: (w - 1500) mod SWEEP_PERIOD
    localparam int unsigned PHASE_ZERO_I =
        (SWEEP_PERIOD - (PHASE_OFFSET % SWEEP_PERIOD)) % SWEEP_PERIOD;
    localparam int unsigned PHASE_FORCED_I =
        ((3000 % SWEEP_PERIOD) + SWEEP_PERIOD - (PHASE_OFFSET % SWEEP_PERIOD)) % SWEEP_PERIOD;
    localparam logic [PHASE_W-1:0] PHASE_ZERO   = PHASE_W'(PHASE_ZERO_I);
    localparam logic [PHASE_W-1:0] PHASE_FORCED = PHASE_W'(PHASE_FORCED_I);
    localparam logic [PHASE_W-1:0] PHASE_LAST   = PHASE_W'(SWEEP_PERIOD - 1);

    localparam int unsigned PROD_W = ROW_W + GAIN_W;   // err * gain
    localparam int unsigned STEP_W = PROD_W - 8;       // back to Q8.8
    localparam int unsigned SUM_W  = STEP_W + 3;       // signed pose arithmetic

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [ROW_W-1:0]  center_row_reg;
    logic [ROW_W-1:0]  upper_row_reg;
    logic [ROW_W-1:0]  lower_row_reg;
    logic [GAIN_W-1:0] gain_reg;
    logic [DEG_W-1:0]  pose_min_reg;
    logic [DEG_W-1:0]  pose_max_reg;
    logic [TICK_W-1:0] valid_ticks_reg;
    logic [TICK_W-1:0] lost_ticks_reg;

    // Register writes never stall.
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_row_reg  <= CENTER_ROW_RESET;
            upper_row_reg   <= UPPER_ROW_RESET;
            lower_row_reg   <= LOWER_ROW_RESET;
            gain_reg        <= GAIN_RESET;
            pose_min_reg    <= POSE_MIN_RESET;
            pose_max_reg    <= POSE_MAX_RESET;
            valid_ticks_reg <= VALID_TICKS_RESET;
            lost_ticks_reg  <= LOST_TICKS_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                CFG_CENTER_ROW:  center_row_reg  <= cfg.data[ROW_W-1:0];
                CFG_UPPER_ROW:   upper_row_reg   <= cfg.data[ROW_W-1:0];
                CFG_LOWER_ROW:   lower_row_reg   <= cfg.data[ROW_W-1:0];
                CFG_GAIN:        gain_reg        <= cfg.data[GAIN_W-1:0];
                CFG_POSE_MIN:    pose_min_reg    <= cfg.data[DEG_W-1:0];
                CFG_POSE_MAX:    pose_max_reg    <= cfg.data[DEG_W-1:0];
                CFG_VALID_TICKS: valid_ticks_reg <= cfg.data[TICK_W-1:0];
                CFG_LOST_TICKS:  lost_ticks_reg  <= cfg.data[TICK_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Result buffer handshake
    // ------------------------------------------------------------------
    logic    out_valid_reg;
    logic    skid_valid_reg;
    result_t out_reg;
    result_t skid_reg;
    result_t result_next;
    logic    item_accept;
    logic    result_pop;

    // Take a new request as long as the skid entry is free.
    assign items.ready = !skid_valid_reg;
    assign item_accept = items.valid && items.ready;
    assign result_pop  = out_valid_reg && results.ready;

    // ------------------------------------------------------------------
    // Tracker state
    // ------------------------------------------------------------------
    logic [POSE_W-1:0]   pose_reg, pose_next;
    logic [TICK_W-1:0]   watchdog_reg, watchdog_next;
    logic [PHASE_W-1:0]  phase_reg, phase_next;
    logic [SEEN_W-1:0]   seen_reg, seen_next;
    logic                locked_reg, locked_next;
    logic                valid_flag_reg, valid_flag_next;
    logic                lost_reg, lost_next;
    logic [LOWCNT_W-1:0] low_cnt_reg, low_cnt_next;
    logic [DEG_W-1:0]    servo_reg, servo_next;

    // Integer part of a Q8.8 pose, clamped to the servo travel.
    function automatic logic [DEG_W-1:0] servo_of(input logic [POSE_W-1:0] q88);
        logic [DEG_W-1:0] pos;
        pos = q88[POSE_W-1:8];
        if (pos > SERVO_MAX)
        begin
            pos = SERVO_MAX;
        end
        if (pos < SERVO_MIN)
        begin
            pos = SERVO_MIN;
        end
        return pos;
    endfunction

    // Detection pose move: step = |row - center| * gain, back to Q8.8.
    logic [ROW_W-1:0]         row_err;
    logic [PROD_W-1:0]        err_prod;
    logic [STEP_W-1:0]        pose_step;
    logic signed [SUM_W-1:0]  pose_s0, pose_s1, pose_s2, pose_s3, pose_s4;
    logic signed [SUM_W-1:0]  step_s, pose_hi_s, pose_lo_s;
    logic [POSE_W-1:0]        pose_det;

    always_comb
    begin
        row_err   = (items.tag_row >= center_row_reg) ? (items.tag_row - center_row_reg)
                                                      : (center_row_reg - items.tag_row);
        err_prod  = PROD_W'(row_err) * PROD_W'(gain_reg);
        pose_step = err_prod[PROD_W-1:8];
        step_s    = signed'(SUM_W'(pose_step));
        pose_s0   = signed'(SUM_W'(pose_reg));
        pose_hi_s = signed'(SUM_W'({pose_max_reg, 8'h00}));
        pose_lo_s = signed'(SUM_W'({pose_min_reg, 8'h00}));
        // Both moves apply if the deadband edges cross: down first, then up.
        pose_s1 = (items.tag_row >= upper_row_reg) ? (pose_s0 - step_s) : pose_s0;
        pose_s2 = (items.tag_row < lower_row_reg)  ? (pose_s1 + step_s) : pose_s1;
        // Clamp to the top first, so the floor wins when the limits cross.
        pose_s3 = (pose_s2 > pose_hi_s) ? pose_hi_s : pose_s2;
        pose_s4 = (pose_s3 < pose_lo_s) ? pose_lo_s : pose_s3;
        pose_det = pose_s4[POSE_W-1:0];
    end

    // State update for the request at the input.
    logic              send;
    logic [POSE_W-1:0] send_pose;
    logic [POSE_W-1:0] sweep_pose;
    logic [POSE_W-1:0] sweep_dec;
    logic [DEG_W-1:0]  send_pos;

    always_comb
    begin
        pose_next       = pose_reg;
        watchdog_next   = watchdog_reg;
        phase_next      = phase_reg;
        seen_next       = seen_reg;
        locked_next     = locked_reg;
        valid_flag_next = valid_flag_reg;
        lost_next       = lost_reg;
        low_cnt_next    = low_cnt_reg;
        servo_next      = servo_reg;
        send            = 1'b0;
        send_pose       = pose_det;
        sweep_pose      = lost_reg ? pose_reg : LOST_START_POSE;
        sweep_dec       = (sweep_pose >= POSE_ONE_DEG) ? (sweep_pose - POSE_ONE_DEG) : '0;
        send_pos        = servo_of(send_pose);

        if (items.command == CMD_DETECT)
        begin
            // Target sightings count toward lock-on; any tag feeds the watchdog.
            if (items.tag_id == TARGET_ID)
            begin
                if (seen_reg < SEEN_MAX)
                begin
                    seen_next = seen_reg + 1'b1;
                end
                if (seen_next > LOCK_SEEN)
                begin
                    locked_next = 1'b1;
                end
                valid_flag_next = 1'b1;
            end
            watchdog_next = '0;
            phase_next    = PHASE_ZERO;
            lost_next     = 1'b0;
            pose_next     = pose_det;
            send          = 1'b1;
            send_pose     = pose_det;
        end
        else
        begin
            if (watchdog_reg != '1)
            begin
                watchdog_next = watchdog_reg + 1'b1;
            end
            phase_next = (phase_reg == PHASE_LAST) ? '0 : (phase_reg + 1'b1);
            if (watchdog_next > valid_ticks_reg)
            begin
                valid_flag_next = 1'b0;
            end
            if (watchdog_next > lost_ticks_reg)
            begin
                // Lost sweep: restart at the top on entry, step down once a period.
                valid_flag_next = 1'b0;
                lost_next       = 1'b1;
                pose_next       = sweep_pose;
                if (phase_next == '0)
                begin
                    send      = 1'b1;
                    send_pose = sweep_dec;
                    pose_next = (sweep_dec == '0) ? LOST_START_POSE : sweep_dec;
                end
            end
        end

        send_pos = servo_of(send_pose);
        if (send)
        begin
            servo_next = send_pos;
            if (send_pos <= LOW_ANGLE_POS)
            begin
                if (low_cnt_reg < LOW_CNT_MAX)
                begin
                    low_cnt_next = low_cnt_reg + 1'b1;
                end
            end
            else
            begin
                low_cnt_next = '0;
            end
            // A long run of low angles without lock forces the watchdog toward lost.
            if ((low_cnt_next > LOW_CNT_TRIP) && !locked_next)
            begin
                watchdog_next = FORCED_WATCHDOG;
                phase_next    = PHASE_FORCED;
            end
        end

        result_next.servo_pos     = servo_next;
        result_next.servo_write   = send;
        result_next.track_valid   = valid_flag_next;
        result_next.tag_lost      = lost_next;
        result_next.target_locked = locked_next;
    end

    // Advance the state only on an accepted request.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pose_reg       <= POSE_RESET;
            watchdog_reg   <= '0;
            phase_reg      <= PHASE_ZERO;
            seen_reg       <= '0;
            locked_reg     <= 1'b0;
            valid_flag_reg <= 1'b0;
            lost_reg       <= 1'b0;
            low_cnt_reg    <= '0;
            servo_reg      <= SERVO_RESET;
        end
        else if (item_accept)
        begin
            pose_reg       <= pose_next;
            watchdog_reg   <= watchdog_next;
            phase_reg      <= phase_next;
            seen_reg       <= seen_next;
            locked_reg     <= locked_next;
            valid_flag_reg <= valid_flag_next;
            lost_reg       <= lost_next;
            low_cnt_reg    <= low_cnt_next;
            servo_reg      <= servo_next;
        end
    end

    // ------------------------------------------------------------------
    // Two-entry result buffer
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (skid_valid_reg)
            begin
                // No request can enter here; drain the skid into the head.
                if (result_pop)
                begin
                    skid_valid_reg <= 1'b0;
                end
            end
            else if (item_accept)
            begin
                if (out_valid_reg && !result_pop)
                begin
                    skid_valid_reg <= 1'b1;
                end
                else
                begin
                    out_valid_reg <= 1'b1;
                end
            end
            else if (result_pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (result_pop)
            begin
                out_reg <= skid_reg;
            end
        end
        else if (item_accept)
        begin
            if (out_valid_reg && !result_pop)
            begin
                skid_reg <= result_next;
            end
            else
            begin
                out_reg <= result_next;
            end
        end
    end

    assign results.valid         = out_valid_reg;
    assign results.servo_pos     = out_reg.servo_pos;
    assign results.servo_write   = out_reg.servo_write;
    assign results.track_valid   = out_reg.track_valid;
    assign results.tag_lost      = out_reg.tag_lost;
    assign results.target_locked = out_reg.target_locked;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // The skid entry only fills behind a waiting head.
    a_skid_behind_head: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry valid without head result");

    // Lost sweep never runs with tracking still marked valid.
    a_lost_not_valid: assert property (@(posedge clk) disable iff (!rst_n)
        lost_reg |-> !valid_flag_reg)
        else $error("lost and valid flags both set");

    // Lock-on needs more than three target sightings.
    a_lock_needs_seen: assert property (@(posedge clk) disable iff (!rst_n)
        locked_reg |-> (seen_reg > LOCK_SEEN))
        else $error("locked with too few sightings");

    // Servo position stays inside the mechanical travel.
    a_servo_range: assert property (@(posedge clk) disable iff (!rst_n)
        (servo_reg >= SERVO_MIN) && (servo_reg <= SERVO_MAX))
        else $error("servo position out of travel");

    // A tick that sends a position always comes from the lost sweep.
    a_sweep_send: assert property (@(posedge clk) disable iff (!rst_n)
        (item_accept && (items.command == CMD_TICK) && send) |=> lost_reg)
        else $error("tick sent servo outside lost sweep");

endmodule

[tb/sv/tilt_servo_tag_tracker_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench of the tilt servo tag tracker: directed probes, random traffic, sweeps.
module tilt_servo_tag_tracker_tb;
    import tst_pkg::*;

    // Match the default sweep period of the block under test.
    localparam int unsigned SWEEP_PERIOD  = 50;
    localparam int          IDLE_PCT      = 36;
    localparam int          RESET_CYCLES  = 7;
    localparam int          SETTLE_CYCLES = 8;
    localparam int          HOLD_CYCLES   = 300;
    localparam int          REPORT_MAX    = 10;
    localparam int          LIMIT         = 100000;
    localparam int          N_PROBES      = 16;

    logic clk;
    logic rst_n;

    tst_item_if   items_if ();
    tst_result_if res_if ();
    tst_cfg_if    cfg_if ();

    tilt_servo_tag_tracker #(
        .SWEEP_PERIOD(SWEEP_PERIOD)
    ) DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_if),
        .items   (items_if),
        .results (res_if)
    );

    // 8 ns clock.
    initial clk = 1'b0;
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Tracker state as the testbench sees it. Register copy is indexed by
    // the package register codes, so the reset values go in code order.
    // ------------------------------------------------------------------
    logic [CFG_DATA_W-1:0] tracker_cfg [8] = '{
        CFG_DATA_W'(CENTER_ROW_RESET), CFG_DATA_W'(UPPER_ROW_RESET),
        CFG_DATA_W'(LOWER_ROW_RESET), GAIN_RESET,
        CFG_DATA_W'(POSE_MIN_RESET), CFG_DATA_W'(POSE_MAX_RESET),
        VALID_TICKS_RESET, LOST_TICKS_RESET
    };

    logic [POSE_W-1:0]   pose_q88   = POSE_RESET;
    logic [TICK_W-1:0]   wd_count   = '0;
    int                  sweep_ph   = 0;
    logic [SEEN_W-1:0]   seen_cnt   = '0;
    bit                  locked_st  = 1'b0;
    bit                  valid_st   = 1'b0;
    bit                  lost_st    = 1'b0;
    logic [LOWCNT_W-1:0] low_cnt    = '0;
    logic [DEG_W-1:0]    servo_last = SERVO_RESET;

    // Servo results still owed by the block, oldest first.
    result_t servo_expect_q [$];

    int  faults       = 0;
    int  holds_asked  = 0;
    bit  steady       = 1'b0;   // set: neither side idles
    int  cycle_count  = 0;

    localparam result_t NO_TYPED = '0;

    // Directed probes. Only the opening rows carry a typed-in result: a tick
    // right after reset, and target sightings inside the deadband that leave
    // the pose at its reset value without reaching lock-on.
    typedef struct packed {
        logic            cmd;
        logic [ID_W-1:0]  id;
        logic [ROW_W-1:0] row;
        bit               has_typed;
        result_t          typed_res;
    } probe_row_t;

    probe_row_t probe_tbl [N_PROBES] = '{
        '{CMD_TICK,   10'd0,    10'd0,    1'b1, '{8'd100, 1'b0, 1'b0, 1'b0, 1'b0}},
        '{CMD_DETECT, 10'd25,   10'd240,  1'b1, '{8'd100, 1'b1, 1'b1, 1'b0, 1'b0}},
        // just under the upper edge: no move
        '{CMD_DETECT, 10'd25,   10'd249,  1'b1, '{8'd100, 1'b1, 1'b1, 1'b0, 1'b0}},
        // on the lower edge: no move, third sighting is still not a lock
        '{CMD_DETECT, 10'd25,   10'd230,  1'b1, '{8'd100, 1'b1, 1'b1, 1'b0, 1'b0}},
        '{CMD_DETECT, 10'd1023, 10'd1023, 1'b0, NO_TYPED},
        '{CMD_DETECT, 10'd0,    10'd0,    1'b0, NO_TYPED},
        // on the upper edge: moves down
        '{CMD_DETECT, 10'd682,  10'd250,  1'b0, NO_TYPED},
        // one under the lower edge: moves up
        '{CMD_DETECT, 10'd341,  10'd229,  1'b0, NO_TYPED},
        '{CMD_DETECT, 10'd24,   10'd341,  1'b0, NO_TYPED},
        '{CMD_DETECT, 10'd26,   10'd682,  1'b0, NO_TYPED},
        '{CMD_TICK,   10'd1023, 10'd1023, 1'b0, NO_TYPED},
        '{CMD_DETECT, 10'd1000, 10'd1023, 1'b0, NO_TYPED},
        '{CMD_DETECT, 10'd1000, 10'd1023, 1'b0, NO_TYPED},
        '{CMD_DETECT, 10'd1000, 10'd1023, 1'b0, NO_TYPED},
        '{CMD_TICK,   10'd512,  10'd512,  1'b0, NO_TYPED},
        '{CMD_DETECT, 10'd512,  10'd512,  1'b0, NO_TYPED}
    };

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic int phase_at(input int unsigned wd);
        return ((wd % SWEEP_PERIOD) + SWEEP_PERIOD - (PHASE_OFFSET % SWEEP_PERIOD))
               % SWEEP_PERIOD;
    endfunction

    // Send the integer part of the pose, clamped to the servo range, and
    // advance the low-angle run; a long run while unlocked forces the
    // watchdog to FORCED_WATCHDOG.
    function automatic void command_servo(input logic [POSE_W-1:0] q88);
        logic [DEG_W-1:0] pos;
        pos = q88[POSE_W-1:8];
        if (pos > SERVO_MAX)
            pos = SERVO_MAX;
        if (pos < SERVO_MIN)
            pos = SERVO_MIN;
        servo_last = pos;
        if (pos <= LOW_ANGLE_POS)
        begin
            if (low_cnt < LOW_CNT_MAX)
                low_cnt++;
        end
        else
            low_cnt = '0;
        if (low_cnt > LOW_CNT_TRIP && !locked_st)
        begin
            wd_count = FORCED_WATCHDOG;
            sweep_ph = phase_at(FORCED_WATCHDOG);
        end
    endfunction

    // Apply one request to the tracker state and return the result it causes.
    function automatic result_t track_step(input logic cmd, input logic [ID_W-1:0] id,
                                           input logic [ROW_W-1:0] row);
        result_t res;
        bit      wrote;
        int      p, err, step, ctr, hi, lo;
        wrote = 1'b0;
        if (cmd == CMD_DETECT)
        begin
            if (id == TARGET_ID)
            begin
                if (seen_cnt < SEEN_MAX)
                    seen_cnt++;
                if (seen_cnt > LOCK_SEEN)
                    locked_st = 1'b1;
                valid_st = 1'b1;
            end
            wd_count = '0;
            sweep_ph = phase_at(0);
            lost_st  = 1'b0;
            ctr  = int'(tracker_cfg[CFG_CENTER_ROW][ROW_W-1:0]);
            err  = (int'(row) >= ctr) ? int'(row) - ctr : ctr - int'(row);
            step = (err * int'(tracker_cfg[CFG_GAIN])) >> 8;
            p    = int'(pose_q88);
            if (row >= tracker_cfg[CFG_UPPER_ROW][ROW_W-1:0])
                p = p - step;
            if (row < tracker_cfg[CFG_LOWER_ROW][ROW_W-1:0])
                p = p + step;
            // Clamp to the top first, then the bottom: the bottom wins if they cross.
            hi = int'(tracker_cfg[CFG_POSE_MAX][DEG_W-1:0]) << 8;
            lo = int'(tracker_cfg[CFG_POSE_MIN][DEG_W-1:0]) << 8;
            if (p > hi)
                p = hi;
            if (p < lo)
                p = lo;
            if (p < 0)
                p = 0;
            pose_q88 = p[POSE_W-1:0];
            command_servo(pose_q88);
            wrote = 1'b1;
        end
        else
        begin
            if (wd_count != '1)
                wd_count++;
            sweep_ph = (sweep_ph + 1) % SWEEP_PERIOD;
            if (wd_count > tracker_cfg[CFG_VALID_TICKS])
                valid_st = 1'b0;
            if (wd_count > tracker_cfg[CFG_LOST_TICKS])
            begin
                valid_st = 1'b0;
                if (!lost_st)
                begin
                    lost_st  = 1'b1;
                    pose_q88 = LOST_START_POSE;
                end
                // Step the sweep down one degree per period, reload at zero.
                if (sweep_ph == 0)
                begin
                    pose_q88 = (pose_q88 >= POSE_ONE_DEG) ? pose_q88 - POSE_ONE_DEG : '0;
                    command_servo(pose_q88);
                    wrote = 1'b1;
                    if (pose_q88 == '0)
                        pose_q88 = LOST_START_POSE;
                end
            end
        end
        res.servo_pos     = servo_last;
        res.servo_write   = wrote;
        res.track_valid   = valid_st;
        res.tag_lost      = lost_st;
        res.target_locked = locked_st;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Result side: compare every accepted result with the oldest one owed.
    // ------------------------------------------------------------------
    function automatic void check_result();
        result_t got, want;
        got.servo_pos     = res_if.servo_pos;
        got.servo_write   = res_if.servo_write;
        got.track_valid   = res_if.track_valid;
        got.tag_lost      = res_if.tag_lost;
        got.target_locked = res_if.target_locked;
        if (servo_expect_q.size() == 0)
        begin
            faults++;
            if (faults <= REPORT_MAX)
                $display("%0t: result with no request pending: pos=%0d write=%0b",
                         $time, got.servo_pos, got.servo_write);
            return;
        end
        want = servo_expect_q.pop_front();
        if (got.servo_pos !== want.servo_pos || got.servo_write !== want.servo_write ||
            got.track_valid !== want.track_valid || got.tag_lost !== want.tag_lost ||
            got.target_locked !== want.target_locked)
        begin
            faults++;
            if (faults <= REPORT_MAX)
            begin
                $display("%0t: result mismatch", $time);
                $display("    expected pos=%0d write=%0b valid=%0b lost=%0b locked=%0b",
                         want.servo_pos, want.servo_write, want.track_valid,
                         want.tag_lost, want.target_locked);
                $display("    actual   pos=%0d write=%0b valid=%0b lost=%0b locked=%0b",
                         got.servo_pos, got.servo_write, got.track_valid,
                         got.tag_lost, got.target_locked);
            end
        end
    endfunction

    // Sample at the rising edge, before the block updates its outputs.
    always @(posedge clk)
    begin
        if (rst_n && res_if.valid === 1'b1 && res_if.ready === 1'b1)
            check_result();
    end

    // Drive ready at the falling edge: random idling, or a long hold-off
    // when the stimulus asks for one so the block fills and stalls its input.
    initial
    begin : result_drain
        int hold_left;
        int holds_served;
        hold_left    = 0;
        holds_served = 0;
        res_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (holds_served != holds_asked)
            begin
                holds_served = holds_asked;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                res_if.ready <= 1'b0;
            end
            else
                res_if.ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // ------------------------------------------------------------------
    // Request and register drivers
    // ------------------------------------------------------------------

    // Offer one request after random idle cycles; predict it once taken.
    task automatic put_item(input logic cmd, input logic [ID_W-1:0] id,
                            input logic [ROW_W-1:0] row, input bit has_typed,
                            input result_t typed_res);
        result_t predicted;
        @(negedge clk);
        while (!steady && $urandom_range(0, 99) < IDLE_PCT)
        begin
            items_if.valid <= 1'b0;
            @(negedge clk);
        end
        items_if.valid   <= 1'b1;
        items_if.command <= cmd;
        items_if.tag_id  <= id;
        items_if.tag_row <= row;
        @(posedge clk);
        while (items_if.ready !== 1'b1)
            @(posedge clk);
        predicted = track_step(cmd, id, row);
        servo_expect_q.push_back(has_typed ? typed_res : predicted);
    endtask

    task automatic put_ticks(input int count);
        repeat (count)
            put_item(CMD_TICK, ID_W'($urandom_range(0, 1023)),
                     ROW_W'($urandom_range(0, 1023)), 1'b0, NO_TYPED);
    endtask

    // Drop the request line and wait until every owed result is back.
    task automatic settle();
        @(negedge clk);
        items_if.valid <= 1'b0;
        while (servo_expect_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= value;
        @(posedge clk);
        while (cfg_if.ready !== 1'b1)
            @(posedge clk);
        tracker_cfg[idx] = value;
    endtask

    // Write the full register set; only call while the block is idle.
    task automatic load_config(input logic [CFG_DATA_W-1:0] center, upper, lower, gain,
                               input logic [CFG_DATA_W-1:0] pmin, pmax, vticks, lticks);
        write_reg(CFG_CENTER_ROW, center);
        write_reg(CFG_UPPER_ROW, upper);
        write_reg(CFG_LOWER_ROW, lower);
        write_reg(CFG_GAIN, gain);
        write_reg(CFG_POSE_MIN, pmin);
        write_reg(CFG_POSE_MAX, pmax);
        write_reg(CFG_VALID_TICKS, vticks);
        write_reg(CFG_LOST_TICKS, lticks);
        @(negedge clk);
        cfg_if.valid <= 1'b0;
    endtask

    // Mixed traffic: single detections, short tick bursts and now and then a
    // longer tick run of up to 100 ticks that can cross low watchdog levels.
    task automatic random_traffic(input int n_items, input bit target_ok);
        int               sent;
        int               tick_run;
        logic [ID_W-1:0]  id;
        logic [ROW_W-1:0] row;
        sent = 0;
        while (sent < n_items)
        begin
            if ($urandom_range(0, 9) < 6)
            begin
                id = ID_W'($urandom_range(0, 1023));
                if (target_ok && $urandom_range(0, 3) == 0)
                    id = TARGET_ID;
                else if (!target_ok && id == TARGET_ID)
                    id = TARGET_ID + 1'b1;
                // Half the rows land near the center to hit the deadband edges.
                if ($urandom_range(0, 1) == 0)
                    row = ROW_W'($urandom_range(0, 1023));
                else
                    row = ROW_W'(int'(tracker_cfg[CFG_CENTER_ROW][ROW_W-1:0])
                                 + $urandom_range(0, 40) - 20);
                put_item(CMD_DETECT, id, row, 1'b0, NO_TYPED);
                sent++;
            end
            else
            begin
                tick_run = ($urandom_range(0, 11) == 0) ? $urandom_range(20, 100)
                                                         : $urandom_range(1, 4);
                put_ticks(tick_run);
                sent += tick_run;
            end
        end
    endtask

    // Cycle counter: end the run if it hangs.
    initial
    begin : run_limit
        while (cycle_count < LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        int               i;
        int               tick_run;
        logic [ID_W-1:0]  id;

        // Hold every input at a known value through reset.
        rst_n            = 1'b0;
        items_if.valid   = 1'b0;
        items_if.command = CMD_TICK;
        items_if.tag_id  = '0;
        items_if.tag_row = '0;
        cfg_if.valid     = 1'b0;
        cfg_if.index     = CFG_CENTER_ROW;
        cfg_if.data      = '0;
        sweep_ph         = phase_at(0);
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Walk the directed probes on the reset register values.
        for (i = 0; i < N_PROBES; i++)
            put_item(probe_tbl[i].cmd, probe_tbl[i].id, probe_tbl[i].row,
                     probe_tbl[i].has_typed, probe_tbl[i].typed_res);
        settle();

        // Low-angle run while still unlocked: cap the pose low so every
        // detection sends a low angle and push the count past the trip level.
        // Use non-target tags only, keeping lock-on off. Keep tick bursts
        // short of a sweep step, since a sweep send is a high angle and would
        // clear the count.
        load_config(CFG_DATA_W'(CENTER_ROW_RESET), CFG_DATA_W'(UPPER_ROW_RESET),
                    CFG_DATA_W'(LOWER_ROW_RESET), GAIN_RESET,
                    16'd0, 16'd60, VALID_TICKS_RESET, LOST_TICKS_RESET);
        for (i = 0; i < 130; i++)
        begin
            id = ID_W'($urandom_range(0, 1023));
            if (id == TARGET_ID)
                id = TARGET_ID + 1'b1;
            put_item(CMD_DETECT, id, ROW_W'($urandom_range(0, 1023)), 1'b0, NO_TYPED);
            if ($urandom_range(0, 19) == 0)
            begin
                tick_run = $urandom_range(1, 12);
                put_ticks(tick_run);
            end
        end
        settle();

        // Random traffic over several register settings; lock-on happens here.
        // Hold off the result side once at the start of the first setting.
        load_config(CFG_DATA_W'(CENTER_ROW_RESET), CFG_DATA_W'(UPPER_ROW_RESET),
                    CFG_DATA_W'(LOWER_ROW_RESET), GAIN_RESET,
                    CFG_DATA_W'(POSE_MIN_RESET), CFG_DATA_W'(POSE_MAX_RESET),
                    VALID_TICKS_RESET, LOST_TICKS_RESET);
        holds_asked++;
        random_traffic(60, 1'b1);
        settle();

        // All registers at zero: lost on the first tick, then the sweep runs.
        load_config(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        random_traffic(40, 1'b1);
        settle();

        // All registers at their top values.
        load_config(16'd1023, 16'd1023, 16'd1023, 16'hFFFF, 16'd255, 16'd255,
                    16'hFFFF, 16'hFFFF);
        random_traffic(40, 1'b1);
        settle();

        // Crossed bands: lower above upper moves both ways, pose_min above
        // pose_max wins. Run this one without idling on either side.
        steady = 1'b1;
        load_config(16'd512, 16'd200, 16'd600, 16'd40000, 16'd200, 16'd60, 16'd5, 16'd30);
        random_traffic(50, 1'b1);
        settle();
        steady = 1'b0;

        // Random register values, upper bits included; tick thresholds kept at or under 150 and 300.
        load_config(CFG_DATA_W'($urandom), CFG_DATA_W'($urandom), CFG_DATA_W'($urandom),
                    CFG_DATA_W'($urandom), CFG_DATA_W'($urandom), CFG_DATA_W'($urandom),
                    CFG_DATA_W'($urandom_range(0, 150)),
                    CFG_DATA_W'($urandom_range(0, 300)));
        random_traffic(40, 1'b1);
        settle();

        // Lost sweep: past the lost level on the second tick, then step down
        // one degree per period. Long stretch with no idling.
        steady = 1'b1;
        load_config(CFG_DATA_W'(CENTER_ROW_RESET), CFG_DATA_W'(UPPER_ROW_RESET),
                    CFG_DATA_W'(LOWER_ROW_RESET), GAIN_RESET,
                    CFG_DATA_W'(POSE_MIN_RESET), CFG_DATA_W'(POSE_MAX_RESET),
                    16'd0, 16'd1);
        put_item(CMD_DETECT, TARGET_ID, CENTER_ROW_RESET, 1'b0, NO_TYPED);
        put_ticks(110);
        settle();
        steady = 1'b0;

        if (faults == 0 && servo_expect_q.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

[filelist.f]
rtl/tst_pkg.sv
rtl/tst_if.sv
rtl/tilt_servo_tag_tracker.sv
tb/sv/tilt_servo_tag_tracker_tb.sv
